// File: design/priority_map_rule_budget_check_macros.svh
// Assertion macros used by the rule-budget check checker.
// Needs nothing else; included by the checker file.
`ifndef PRIORITY_MAP_RULE_BUDGET_CHECK_MACROS_SVH
`define PRIORITY_MAP_RULE_BUDGET_CHECK_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset
`define PMRBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset
`define PMRBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pmrbc_pkg.sv
// Shared types and constants of the priority-map rule-budget check.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pmrbc_pkg;

  localparam int NUM_PORTS_DEF = 32;
  localparam int PORT_W        = 6;
  localparam int PRIO_W        = 3;
  localparam int PRIOS         = 8;
  localparam int MAP_W         = PRIO_W * PRIOS;
  localparam int RULE_W        = 9;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [RULE_W-1:0] RULE_LIMIT_RST = 9'd40;
  localparam logic [RULE_W-1:0] RULES_MAX      = 9'd511;

  // Identity map: entry k holds k
  localparam logic [MAP_W-1:0] IDENTITY_MAP = 24'o76543210;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_RULE_LIMIT = 3'd0;

  typedef logic [MAP_W-1:0] map_t;

  // Map travelling along the ring of cells
  typedef struct packed {
    map_t map;
    logic excl;   // owned by the requesting port
    logic wrap;   // came around from the far end
  } tok_t;

  // Commands broadcast by the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic              scan;
    logic              mark;
    logic              drain;
    logic              write;
    logic [PORT_W-1:0] port;
    logic              have_new;
    map_t              new_map;
  } cell_cmd_t;

  // What a cell shows its right-hand neighbor
  typedef struct packed {
    map_t home;
    logic is_port;
    tok_t tok;
    logic cnt;
  } cell_out_t;

endpackage

// File: design/priority_map_rule_budget_check.sv
// Top level of the priority-map rule-budget check: register port, cell ring, sequencer.
// Depends on pmrbc_pkg, pmrbc_cell and pmrbc_ctrl.
`timescale 1ns / 1ps

// Each request names a port and may carry a new eight-entry priority map. The
// block counts the distinct maps held by all other ports (maps equal to the new
// one left out, one added for the new map), answers with eight rules per map and
// refuses the request when that exceeds rule_limit; an accepted new map for a
// port below NUM_PORTS is stored. One request is handled at a time: the maps
// circulate once around a ring of NUM_PORTS cells to find duplicates, then the
// per-cell count bits shift out of the ring's end into the tally.
// Maps reset to the identity map; rule_limit sits at byte address 0.
module priority_map_rule_budget_check #(
  parameter int NUM_PORTS = pmrbc_pkg::NUM_PORTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pmrbc_pkg::PORT_W-1:0] in_port,
  input  logic                         in_list_present,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_0,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_1,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_2,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_3,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_4,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_5,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_6,
  input  logic [pmrbc_pkg::PRIO_W-1:0] in_prio_7,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_accepted,
  output logic [pmrbc_pkg::RULE_W-1:0] out_rules_needed,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmrbc_pkg::ADDR_W-1:0] paddr,
  input  logic [pmrbc_pkg::DATA_W-1:0] pwdata,
  output logic [pmrbc_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  logic [pmrbc_pkg::RULE_W-1:0] rule_limit_r;
  logic                         sel_limit;
  pmrbc_pkg::map_t              in_map;
  pmrbc_pkg::cell_cmd_t         cmd;
  pmrbc_pkg::cell_out_t         cq [NUM_PORTS];

  // Register decode by word address
  assign sel_limit = (paddr[pmrbc_pkg::ADDR_W-1:2] ==
                      pmrbc_pkg::ADDR_RULE_LIMIT[pmrbc_pkg::ADDR_W-1:2]);
  assign pready    = 1'b1;
  assign prdata    = sel_limit ? pmrbc_pkg::DATA_W'(rule_limit_r) : '0;

  // Hold the rule limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_limit_r <= pmrbc_pkg::RULE_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && sel_limit) begin
      rule_limit_r <= pwdata[pmrbc_pkg::RULE_W-1:0];
    end
  end

  // Pack the request map, entry k in bits 3k+2..3k
  assign in_map = {in_prio_7, in_prio_6, in_prio_5, in_prio_4,
                   in_prio_3, in_prio_2, in_prio_1, in_prio_0};

  pmrbc_ctrl #(
    .NUM_PORTS(NUM_PORTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_port         (in_port),
    .in_list_present (in_list_present),
    .in_map          (in_map),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_rules_needed(out_rules_needed),
    .rule_limit      (rule_limit_r),
    .tail_cnt        (cq[NUM_PORTS-1].cnt),
    .cmd             (cmd)
  );

  // Ring of cells; cell 0 takes from the last one and marks the wrap
  for (genvar i = 0; i < NUM_PORTS; i++) begin : g_cell
    pmrbc_pkg::cell_out_t left;

    if (i == 0) begin : g_head
      always_comb begin
        left     = cq[NUM_PORTS-1];
        left.cnt = 1'b0;
      end
    end else begin : g_body
      assign left = cq[i-1];
    end

    pmrbc_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .left   (left),
      .wrap_in(i == 0),
      .q      (cq[i])
    );
  end

endmodule

// File: design/pmrbc_cell.sv
// One cell of the map ring: holds one port's map, compares passing maps.
// Depends on pmrbc_pkg.
`timescale 1ns / 1ps

module pmrbc_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmrbc_pkg::cell_cmd_t cmd,
  input  pmrbc_pkg::cell_out_t left,
  input  logic                 wrap_in,
  output pmrbc_pkg::cell_out_t q
);

  pmrbc_pkg::map_t home_r;
  pmrbc_pkg::tok_t tok_r;
  pmrbc_pkg::tok_t tok_nxt;
  logic            dup_r;
  logic            cnt_r;
  logic            is_port;
  logic            hit;

  assign is_port = (cmd.port == pmrbc_pkg::PORT_W'(IDX));

  // Earlier port (no wrap), not the requester, same map
  assign hit = !tok_r.wrap && !tok_r.excl && (tok_r.map == home_r);

  // Token taken from the left neighbor: its home map on load, its token on scan
  always_comb begin
    if (cmd.load) begin
      tok_nxt = '{map: left.home, excl: left.is_port, wrap: wrap_in};
    end else begin
      tok_nxt = '{map: left.tok.map, excl: left.tok.excl, wrap: left.tok.wrap | wrap_in};
    end
  end

  // Hold the port's map; store an accepted new map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r <= pmrbc_pkg::IDENTITY_MAP;
    end else if (cmd.write && is_port) begin
      home_r <= cmd.new_map;
    end
  end

  // Advance the token ring
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan) begin
      tok_r <= tok_nxt;
    end
  end

  // Track duplicates and shift the count bits out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= 1'b0;
      cnt_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        dup_r <= 1'b0;
      end else if (cmd.scan && hit) begin
        dup_r <= 1'b1;
      end
      if (cmd.mark) begin
        cnt_r <= !is_port && !(cmd.have_new && (home_r == cmd.new_map)) && !dup_r;
      end else if (cmd.drain) begin
        cnt_r <= left.cnt;
      end
    end
  end

  assign q = '{home: home_r, is_port: is_port, tok: tok_r, cnt: cnt_r};

endmodule

// File: design/pmrbc_ctrl.sv
// Sequencer of the rule-budget check: request latch, ring phases, tally, result.
// Depends on pmrbc_pkg.
`timescale 1ns / 1ps

module pmrbc_ctrl #(
  parameter int NUM_PORTS = pmrbc_pkg::NUM_PORTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pmrbc_pkg::PORT_W-1:0] in_port,
  input  logic                         in_list_present,
  input  pmrbc_pkg::map_t              in_map,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_accepted,
  output logic [pmrbc_pkg::RULE_W-1:0] out_rules_needed,
  input  logic [pmrbc_pkg::RULE_W-1:0] rule_limit,
  input  logic                         tail_cnt,
  output pmrbc_pkg::cell_cmd_t         cmd
);

  localparam int SW    = (NUM_PORTS > 2) ? $clog2(NUM_PORTS) : 1;
  localparam int CNT_W = $clog2(NUM_PORTS + 2);
  localparam int CMP_W = (CNT_W + 3 > pmrbc_pkg::RULE_W) ? CNT_W + 3 : pmrbc_pkg::RULE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_MARK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                         state_r;
  logic [SW-1:0]                  step_r;
  logic [CNT_W-1:0]               count_r;
  logic [pmrbc_pkg::PORT_W-1:0]   port_r;
  logic                           have_new_r;
  pmrbc_pkg::map_t                map_r;
  logic                           out_valid_r;
  logic                           out_accepted_r;
  logic [pmrbc_pkg::RULE_W-1:0]   out_rules_r;
  logic [CMP_W-1:0]               rules_ext;
  logic [pmrbc_pkg::RULE_W-1:0]   rules_sat;
  logic                           ok;
  logic                           deliver;

  // Rules from the tally, saturated, against the limit
  assign rules_ext = CMP_W'({count_r, 3'b000});
  assign rules_sat = (rules_ext > CMP_W'(pmrbc_pkg::RULES_MAX)) ? pmrbc_pkg::RULES_MAX :
                     rules_ext[pmrbc_pkg::RULE_W-1:0];
  assign ok        = (rules_ext <= CMP_W'(rule_limit));
  assign deliver   = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_rules_needed = out_rules_r;

  // Broadcast the phase to the cells
  always_comb begin
    cmd.load     = (state_r == S_LOAD);
    cmd.scan     = (state_r == S_SCAN);
    cmd.mark     = (state_r == S_MARK);
    cmd.drain    = (state_r == S_DRAIN);
    cmd.write    = deliver && ok && have_new_r;
    cmd.port     = port_r;
    cmd.have_new = have_new_r;
    cmd.new_map  = map_r;
  end

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      port_r     <= in_port;
      have_new_r <= in_list_present;
      map_r      <= in_map;
    end
  end

  // Sequence the phases and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      step_r         <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      out_accepted_r <= 1'b0;
      out_rules_r    <= '0;
    end else begin
      // Drop a taken result unless the next one replaces it in this cycle
      if (out_valid_r && out_ready && !deliver) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          count_r <= CNT_W'(have_new_r);
          step_r  <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          step_r <= step_r + 1'b1;
          if (step_r == SW'(NUM_PORTS - 2)) begin
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          step_r  <= '0;
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          count_r <= count_r + CNT_W'(tail_cnt);
          step_r  <= step_r + 1'b1;
          if (step_r == SW'(NUM_PORTS - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (deliver) begin
            out_valid_r    <= 1'b1;
            out_accepted_r <= ok;
            out_rules_r    <= rules_sat;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/pmrbc_checker.sv
// Port-level checks of the priority-map rule-budget check, bound to the top level.
// Depends on pmrbc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "priority_map_rule_budget_check_macros.svh"

module pmrbc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_accepted,
  input logic [pmrbc_pkg::RULE_W-1:0] out_rules_needed
);

  // A stalled result holds
  `PMRBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rules_needed) && $stable(out_accepted), "result changed while stalled")

  // One request at a time: no acceptance right after one
  `PMRBC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while one is in flight")

  // Rules are whole multiples of eight unless saturated
  `PMRBC_ASSERT_NOW(a_rules_step, clk, rst_n, out_valid, (out_rules_needed[2:0] == 3'd0) || (out_rules_needed == pmrbc_pkg::RULES_MAX), "rule count not a multiple of eight")

  // A saturated count is always refused
  `PMRBC_ASSERT_NOW(a_sat_refused, clk, rst_n, out_valid && (out_rules_needed == pmrbc_pkg::RULES_MAX), !out_accepted, "saturated rule count accepted")

endmodule

bind priority_map_rule_budget_check pmrbc_checker u_pmrbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_accepted    (out_accepted),
  .out_rules_needed(out_rules_needed)
);
